### design/tbp_pkg.sv
package tbp_pkg;

    // Table size and derived address width
    localparam int unsigned PATHS  = 1024;
    localparam int unsigned ADDR_W = (PATHS > 1) ? $clog2(PATHS) : 1;

    // Field widths fixed by the item formats
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned COST_W  = 16;
    localparam int unsigned RATE_W  = 40;
    localparam int unsigned TOK_W   = 32;

    // Refill scaling
    localparam int unsigned ELAPSED_SHIFT = 10;
    localparam int unsigned RATE_SHIFT    = 22;
    localparam int unsigned RATE_HI_W     = RATE_W - RATE_SHIFT;
    // Scaled elapsed time, saturated at 2^TOK_W: any larger value with a
    // non-zero rate already overflows the token range
    localparam int unsigned ELAPSED_W     = TOK_W + 1;
    localparam int unsigned PROD_W        = ELAPSED_W + RATE_HI_W;

    localparam logic ACT_POLICE  = 1'b0;
    localparam logic ACT_INSTALL = 1'b1;

    localparam logic VERDICT_DROP    = 1'b0;
    localparam logic VERDICT_FORWARD = 1'b1;

    typedef struct packed {
        logic                action;
        logic [IDX_W-1:0]    path_index;
        logic [TIME_W-1:0]   now_ns;
        logic [COST_W-1:0]   byte_count;
        logic [RATE_W-1:0]   rate_value;
        logic [TOK_W-1:0]    burst_value;
        logic [TOK_W-1:0]    start_tokens;
    } in_item_t;

    typedef struct packed {
        logic                verdict;
        logic                entry_found;
        logic [TOK_W-1:0]    tokens_left;
    } out_item_t;

    // One bucket entry as held in the table memory
    typedef struct packed {
        logic                 valid;
        logic [TOK_W-1:0]     tokens;
        logic [TIME_W-1:0]    last_time;
        logic [RATE_HI_W-1:0] rate_hi;
        logic [TOK_W-1:0]     capacity;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_SUM,
        ST_WB
    } state_t;

    // Stage enables for the refill datapath
    typedef struct packed {
        logic ld_elapsed;
        logic ld_prod;
        logic ld_sum;
    } refill_ctrl_t;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        return ADDR_W'(idx);
    endfunction

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return (32'(idx) < 32'(PATHS));
    endfunction

endpackage

### design/tbp_ram.sv
module tbp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/tbp_refill.sv
module tbp_refill (
    input  logic                             clk,
    input  tbp_pkg::refill_ctrl_t            ctrl,
    input  logic [tbp_pkg::TIME_W-1:0]       now_ns,
    input  logic [tbp_pkg::TIME_W-1:0]       last_time,
    input  logic [tbp_pkg::RATE_HI_W-1:0]    rate_hi,
    input  logic [tbp_pkg::TOK_W-1:0]        tokens,
    input  logic [tbp_pkg::TOK_W-1:0]        capacity,
    output logic [tbp_pkg::TOK_W-1:0]        capped
);
    import tbp_pkg::*;

    logic [TIME_W-1:0]    diff;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [PROD_W-1:0]    prod_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [TOK_W:0]       sum;
    logic [TOK_W-1:0]     capped_next;
    logic [TOK_W-1:0]     capped_reg;

    // Clamp a negative difference to zero, drop the low bits, and saturate
    // anything past the token range at 2^32
    always_comb
    begin
        diff = now_ns - last_time;
        if (diff[TIME_W-1])
        begin
            elapsed_next = '0;
        end
        else if (|diff[TIME_W-2:TOK_W+ELAPSED_SHIFT])
        begin
            elapsed_next = {1'b1, {TOK_W{1'b0}}};
        end
        else
        begin
            elapsed_next = ELAPSED_W'(diff[TOK_W+ELAPSED_SHIFT-1:ELAPSED_SHIFT]);
        end
    end

    assign prod_next = PROD_W'(elapsed_reg) * PROD_W'(rate_hi);

    // Any refill of 2^32 or more fills the bucket to capacity
    always_comb
    begin
        sum = {1'b0, tokens} + {1'b0, prod_reg[TOK_W-1:0]};
        if (|prod_reg[PROD_W-1:TOK_W])
        begin
            capped_next = capacity;
        end
        else if (sum > {1'b0, capacity})
        begin
            capped_next = capacity;
        end
        else
        begin
            capped_next = sum[TOK_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_elapsed)
        begin
            elapsed_reg <= elapsed_next;
        end
        if (ctrl.ld_prod)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.ld_sum)
        begin
            capped_reg <= capped_next;
        end
    end

    assign capped = capped_reg;

endmodule

### design/token_bucket_policer_table_unit.sv
// Token-bucket policer over a table of PATHS bucket entries held in one
// single-port-write, registered-read memory. Each item is a police or an
// install request and yields exactly one result item. The block works on one
// item at a time: a police item on an installed path passes through the table
// read, elapsed time, refill multiply, refill sum and cap, and cost check with
// write-back steps; an install item or a police item on an empty path goes
// from the table read straight to write-back. The refill multiply of the 33-bit
// saturated elapsed time by the 18-bit scaled rate sets the length of the
// chain. A new item is taken while the previous result still waits in the
// output register.
// After reset the table is swept once to clear every entry, one per cycle, so
// no item is accepted until the sweep is done.
module token_bucket_policer_table_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pkt_valid,
    output logic                 pkt_stall,
    input  tbp_pkg::in_item_t    pkt,
    output logic                 res_valid,
    input  logic                 res_stall,
    output tbp_pkg::out_item_t   res
);
    import tbp_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [ADDR_W-1:0]   clr_cnt_next;
    in_item_t            item_reg;
    logic                in_range_reg;
    entry_t              entry_reg;
    logic                found_reg;
    out_item_t           res_reg;
    out_item_t           res_next;
    logic                res_valid_reg;
    logic                res_valid_next;

    logic                accept;
    logic                res_free;
    logic                clr_done;
    logic                res_load;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    entry_t              ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              rd_entry;

    refill_ctrl_t        rf_ctrl;
    logic [TOK_W-1:0]    capped;
    logic                covers;
    logic [TOK_W-1:0]    tokens_after;
    entry_t              wb_entry;
    logic                wb_write;

    assign accept    = pkt_valid && !pkt_stall;
    assign res_free  = !res_valid_reg || !res_stall;
    assign clr_done  = (clr_cnt_reg == ADDR_W'(PATHS - 1));
    assign rd_entry  = entry_t'(ram_rdata);

    // Table memory: one entry per path
    tbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PATHS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tbp_refill u_refill (
        .clk       (clk),
        .ctrl      (rf_ctrl),
        .now_ns    (item_reg.now_ns),
        .last_time (rd_entry.last_time),
        .rate_hi   (entry_reg.rate_hi),
        .tokens    (entry_reg.tokens),
        .capacity  (entry_reg.capacity),
        .capped    (capped)
    );

    // Cost check against the capped token count
    assign covers       = ({16'b0, item_reg.byte_count} <= capped);
    assign tokens_after = covers ? (capped - TOK_W'(item_reg.byte_count)) : capped;

    // Entry to write back and the result it produces
    always_comb
    begin
        wb_entry = entry_reg;
        res_next = '0;
        wb_write = 1'b0;
        if (item_reg.action == ACT_INSTALL)
        begin
            wb_entry.valid     = 1'b1;
            wb_entry.tokens    = item_reg.start_tokens;
            wb_entry.last_time = item_reg.now_ns;
            wb_entry.rate_hi   = item_reg.rate_value[RATE_W-1:RATE_SHIFT];
            wb_entry.capacity  = item_reg.burst_value;
            res_next.verdict     = VERDICT_FORWARD;
            res_next.entry_found = found_reg;
            res_next.tokens_left = in_range_reg ? item_reg.start_tokens : '0;
            wb_write = in_range_reg;
        end
        else if (found_reg)
        begin
            wb_entry.tokens    = tokens_after;
            wb_entry.last_time = item_reg.now_ns;
            res_next.verdict     = covers ? VERDICT_FORWARD : VERDICT_DROP;
            res_next.entry_found = 1'b1;
            res_next.tokens_left = tokens_after;
            wb_write = 1'b1;
        end
        else
        begin
            // Empty path: forward, leave the table alone
            res_next.verdict     = VERDICT_FORWARD;
            res_next.entry_found = 1'b0;
            res_next.tokens_left = '0;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pkt_valid)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (item_reg.action == ACT_POLICE && rd_entry.valid && in_range_reg)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_WB;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        pkt_stall     = 1'b1;
        ram_we        = 1'b0;
        ram_waddr     = to_addr(item_reg.path_index);
        ram_wdata     = wb_entry;
        ram_re        = 1'b0;
        ram_raddr     = to_addr(pkt.path_index);
        rf_ctrl       = '0;
        res_load      = 1'b0;
        clr_cnt_next  = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                pkt_stall = 1'b0;
                ram_re    = pkt_valid;
            end
            ST_RD:
            begin
                rf_ctrl.ld_elapsed = 1'b1;
            end
            ST_MUL:
            begin
                rf_ctrl.ld_prod = 1'b1;
            end
            ST_SUM:
            begin
                rf_ctrl.ld_sum = 1'b1;
            end
            ST_WB:
            begin
                res_load = res_free;
                ram_we   = res_free && wb_write;
            end
            default:
            begin
                pkt_stall = 1'b1;
            end
        endcase
    end

    // Hold the result until taken; load a new one as the slot frees
    always_comb
    begin
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= pkt;
            in_range_reg <= idx_in_range(pkt.path_index);
        end
        if (state_reg == ST_RD)
        begin
            entry_reg <= rd_entry;
            found_reg <= rd_entry.valid && in_range_reg;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The table is written only by the clearing sweep or at write-back
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_WB))
        else $error("table written outside sweep or write-back");

    // A fresh result comes only from the write-back step
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == ST_WB)
        else $error("result raised without write-back");

    // Only an installed path can drop an item
    a_drop_found: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.verdict == VERDICT_DROP) |-> res_reg.entry_found)
        else $error("drop reported for an empty path");

    // The refill chain runs only for police items on installed paths
    a_refill_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (found_reg && item_reg.action == ACT_POLICE))
        else $error("refill started for install or empty path");

    // No item is taken during the clearing sweep
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !$past(accept))
        else $error("item accepted during clearing sweep");

endmodule

### dv/policer_scoreboard_pkg.sv
`timescale 1ns / 100ps

package policer_scoreboard_pkg;

    import tbp_pkg::*;

    class policer_scoreboard;
        bit                 installed [PATHS];
        logic [TOK_W-1:0]   tokens    [PATHS];
        logic [TIME_W-1:0]  stamp_ns  [PATHS];
        logic [RATE_W-1:0]  rate      [PATHS];
        logic [TOK_W-1:0]   capacity  [PATHS];
        out_item_t          outcome_q [$];
        int unsigned        errors;

        function new();
            foreach (installed[i])
                installed[i] = 1'b0;
            errors = 0;
        endfunction

        // Work out the outcome of one item and advance the bucket table.
        function out_item_t police_item(in_item_t it);
            out_item_t         r;
            int unsigned       p;
            logic [TIME_W-1:0] elapsed;
            logic [127:0]      level;

            r.verdict     = VERDICT_FORWARD;
            r.entry_found = 1'b0;
            r.tokens_left = '0;
            p = int'(it.path_index);
            if (p >= PATHS)
                return r;

            r.entry_found = installed[p];
            if (it.action == ACT_INSTALL)
            begin
                installed[p]  = 1'b1;
                tokens[p]     = it.start_tokens;
                stamp_ns[p]   = it.now_ns;
                rate[p]       = it.rate_value;
                capacity[p]   = it.burst_value;
                r.tokens_left = it.start_tokens;
                return r;
            end
            if (!installed[p])
                return r;

            // Negative elapsed time counts as none; wide sum stands in for saturation.
            elapsed = it.now_ns - stamp_ns[p];
            if (elapsed[TIME_W-1])
                elapsed = '0;
            level = 128'(tokens[p])
                  + 128'(elapsed >> ELAPSED_SHIFT) * 128'(rate[p] >> RATE_SHIFT);
            if (level > 128'(capacity[p]))
                level = 128'(capacity[p]);
            stamp_ns[p] = it.now_ns;
            if (level >= 128'(it.byte_count))
            begin
                level     = level - 128'(it.byte_count);
                r.verdict = VERDICT_FORWARD;
            end
            else
                r.verdict = VERDICT_DROP;
            tokens[p]     = level[TOK_W-1:0];
            r.tokens_left = level[TOK_W-1:0];
            return r;
        endfunction

        function void note_packet(in_item_t it);
            outcome_q.push_back(police_item(it));
        endfunction

        function void check_outcome(out_item_t got);
            out_item_t want;
            if (outcome_q.size() == 0)
            begin
                $display("%0t: unexpected result item: verdict %0d found %0d tokens %0h",
                         $time, got.verdict, got.entry_found, got.tokens_left);
                errors++;
                return;
            end
            want = outcome_q.pop_front();
            if (got.verdict !== want.verdict)
            begin
                $display("%0t: verdict mismatch: expected %0d, actual %0d",
                         $time, want.verdict, got.verdict);
                errors++;
            end
            if (got.entry_found !== want.entry_found)
            begin
                $display("%0t: entry_found mismatch: expected %0d, actual %0d",
                         $time, want.entry_found, got.entry_found);
                errors++;
            end
            if (got.tokens_left !== want.tokens_left)
            begin
                $display("%0t: tokens_left mismatch: expected %0h, actual %0h",
                         $time, want.tokens_left, got.tokens_left);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return outcome_q.size();
        endfunction
    endclass

endpackage

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

    import tbp_pkg::*;
    import policer_scoreboard_pkg::*;

    localparam int unsigned POOL  = 16;
    localparam int unsigned LIMIT = 300000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       pkt_valid = 1'b0;
    logic       pkt_stall;
    in_item_t   pkt       = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    out_item_t  res;

    policer_scoreboard sb = new();

    // Receiver behaviour: per-cycle stall chance, plus a long hold-off flag.
    int unsigned stall_pct = 0;
    bit          hold_res  = 1'b0;
    int unsigned cycles    = 0;

    // Paths that the well-formed traffic keeps returning to, and a running clock
    // for their timestamps.
    int unsigned pool [POOL];
    bit [63:0]   wall_ns = 64'd1000;

    token_bucket_policer_table_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #5 clk = ~clk;

    // Stall the result channel at random, or solidly while a hold-off runs.
    always @(posedge clk)
        res_stall <= hold_res || ($urandom_range(99) < stall_pct);

    // Note every accepted packet item and check every accepted result item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pkt_valid && !pkt_stall)
                sb.note_packet(pkt);
            if (res_valid && !res_stall)
                sb.check_outcome(res);
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Fill every field with random bits.
    function automatic in_item_t scramble();
        bit [223:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return bits[$bits(in_item_t)-1:0];
    endfunction

    function automatic in_item_t packet_item(logic act, int unsigned idx,
                                             logic [TIME_W-1:0] now,
                                             logic [COST_W-1:0] cost,
                                             logic [RATE_W-1:0] rate_v,
                                             logic [TOK_W-1:0] burst,
                                             logic [TOK_W-1:0] start);
        in_item_t it;
        it.action       = act;
        it.path_index   = IDX_W'(idx);
        it.now_ns       = now;
        it.byte_count   = cost;
        it.rate_value   = rate_v;
        it.burst_value  = burst;
        it.start_tokens = start;
        return it;
    endfunction

    // Build a plausible item for one path: advance the clock, now and then
    // step backwards, and keep rates, bursts and costs mostly in a range where
    // buckets both fill and run dry.
    function automatic in_item_t shaped_item(bit install, int unsigned path);
        in_item_t it;
        it = scramble();
        case ($urandom_range(19))
            0:       wall_ns += {$urandom, $urandom} >> $urandom_range(1, 40);
            1, 2, 3: wall_ns += 64'($urandom_range(0, 1 << 22));
            default: wall_ns += 64'($urandom_range(0, 40000));
        endcase
        it.path_index = IDX_W'(path);
        it.now_ns     = ($urandom_range(24) == 0)
                      ? wall_ns - 64'($urandom_range(1, 1 << 20)) : wall_ns;
        if (install)
        begin
            it.action = ACT_INSTALL;
            if ($urandom_range(3) != 0)
                it.rate_value = (RATE_W'($urandom_range(0, 64)) << RATE_SHIFT)
                              | RATE_W'($urandom_range(0, (1 << RATE_SHIFT) - 1));
            if ($urandom_range(3) != 0)
                it.burst_value = $urandom_range(0, 100000);
            if ($urandom_range(3) != 0)
                it.start_tokens = $urandom_range(0, 120000);
        end
        else
        begin
            it.action = ACT_POLICE;
            if ($urandom_range(7) != 0)
                it.byte_count = COST_W'($urandom_range(0, 1500));
        end
        return it;
    endfunction

    // Mostly traffic on the pool paths, one item in ten an install, and a
    // little pure noise on any path.
    function automatic in_item_t next_random_item();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return scramble();
        return shaped_item(roll < 15, pool[$urandom_range(POOL - 1)]);
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic offer(input in_item_t it);
        pkt_valid <= 1'b1;
        pkt       <= it;
        @(posedge clk);
        while (pkt_stall)
            @(posedge clk);
    endtask

    // Drop valid for a random number of cycles, with junk on the payload.
    task automatic idle_gap(input int unsigned pct);
        while ($urandom_range(99) < pct)
        begin
            pkt_valid <= 1'b0;
            pkt       <= scramble();
            @(posedge clk);
        end
    endtask

    // Keep the result channel stalled for a fixed stretch.
    task automatic hold_results(input int unsigned span);
        hold_res <= 1'b1;
        repeat (span) @(posedge clk);
        hold_res <= 1'b0;
    endtask

    // Stop offering items and wait until every expected result has been checked.
    task automatic pause_until_drained();
        pkt_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
                             input int unsigned stall_in);
        stall_pct <= stall_in;
        repeat (count)
        begin
            idle_gap(idle_pct);
            offer(next_random_item());
        end
    endtask

    // Extremes of each field and the corner cases of the bucket arithmetic.
    task automatic run_directed();
        // Police on a path with no entry
        offer(packet_item(ACT_POLICE, 0, '1, '1, '1, '1, '1));
        // Install with the fastest rate and largest burst, then let the refill
        // overflow so the sum saturates and is capped
        offer(packet_item(ACT_INSTALL, 0, '0, '0, '1, '1, '0));
        offer(packet_item(ACT_POLICE, 0, 64'h7FFF_FFFF_FFFF_FFFF, '1, '0, '0, '0));
        // Time goes backwards: no refill
        offer(packet_item(ACT_POLICE, 0, 64'h10, '0, '0, '0, '0));
        // Start above capacity, capped on the next police item
        offer(packet_item(ACT_INSTALL, PATHS - 1, 64'd1000, '0, '0, 32'd100, 32'd500));
        offer(packet_item(ACT_POLICE, PATHS - 1, 64'd5000, 16'd0, '0, '0, '0));
        offer(packet_item(ACT_POLICE, PATHS - 1, 64'd5000, 16'd101, '0, '0, '0));
        offer(packet_item(ACT_POLICE, PATHS - 1, 64'd5000, 16'd100, '0, '0, '0));
        // Overwrite an installed entry
        offer(packet_item(ACT_INSTALL, PATHS - 1, '0, '0, 40'h00_007F_FFFF, 32'd1000, '0));
        // Less than one refill unit of elapsed time, then a longer gap
        offer(packet_item(ACT_POLICE, PATHS - 1, 64'd1023, 16'd1, '0, '0, '0));
        offer(packet_item(ACT_POLICE, PATHS - 1, 64'd51200, 16'd50, '0, '0, '0));
        // Timestamps that wrap, and an elapsed time with the top bit set
        offer(packet_item(ACT_INSTALL, 512, '1, '0, 40'h00_0040_0000, '1, '1));
        offer(packet_item(ACT_POLICE, 512, '0, '1, '0, '0, '0));
        offer(packet_item(ACT_POLICE, 512, 64'h8000_0000_0000_0000, '0, '0, '0, '0));
        offer(packet_item(ACT_POLICE, 0, '1, 16'd1, '0, '0, '0));
    endtask

    initial
    begin
        pool[0] = 0;
        pool[1] = PATHS - 1;
        for (int k = 2; k < POOL; k++)
            pool[k] = $urandom_range(PATHS - 1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The block sweeps its table after reset; offer simply waits it out.
        run_directed();

        // Give every pool path an entry before the random traffic starts.
        foreach (pool[k])
            offer(shaped_item(1'b1, pool[k]));

        // Back-to-back items against a long result hold-off fill the block.
        fork
            hold_results(400);
        join_none
        run_phase(150, 0, 0);
        run_phase(150, 71, 0);
        pause_until_drained();
        run_phase(150, 0, 71);
        run_phase(150, 15, 15);

        pause_until_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
design/tbp_pkg.sv
design/tbp_ram.sv
design/tbp_refill.sv
design/token_bucket_policer_table_unit.sv
dv/policer_scoreboard_pkg.sv
dv/tb.sv
